// ===== rtl/clipped_colour_key_tile_blitter_core_macros.svh =====
// assertion macros shared by the tile blitter rtl
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef CLIPPED_COLOUR_KEY_TILE_BLITTER_CORE_MACROS_SVH
`define CLIPPED_COLOUR_KEY_TILE_BLITTER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define CCKB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define CCKB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cckb_pkg.sv =====
// types and constants for the colour-keyed tile blitter
// no dependencies
`default_nettype none

package cckb_pkg;

	// screen size, fixed by the 9-bit column and 8-bit row of a pixel write
	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 240;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SHEET_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHEET_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_NUMBER  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOUR   = 3'd6;

	// field widths
	localparam int DIM_W    = 11;
	localparam int TNUM_W   = 10;
	localparam int COORD_W  = 16;
	localparam int COLOUR_W = 16;
	localparam int BASE_W   = DIM_W + TNUM_W;
	localparam int SX_OUT_W = 9;
	localparam int SY_OUT_W = 8;

	// screen coordinate sums: 16-bit signed origin plus an offset below 4096
	localparam int SUM_W = 18;
	// tile column difference, wide enough for either sign
	localparam int DIFF_W = BASE_W + 1;

	// stream widths
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_PAD_W  = OUT_DATA_W - SX_OUT_W - SY_OUT_W - COLOUR_W;

	// register file contents seen by the datapath
	typedef struct packed {
		logic [DIM_W-1:0]          sheet_width;
		logic [DIM_W-1:0]          sheet_height;
		logic [DIM_W-1:0]          tile_width;
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic [COLOUR_W-1:0]       key_colour;
		logic [BASE_W-1:0]         tile_base;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/cckb_cfg_regs.sv =====
// configuration registers of the tile blitter, plus the registered tile start column
// depends on cckb_pkg
`default_nettype none

module cckb_cfg_regs
	import cckb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	logic [DIM_W-1:0]          sheet_width_q;
	logic [DIM_W-1:0]          sheet_height_q;
	logic [DIM_W-1:0]          tile_width_q;
	logic [TNUM_W-1:0]         tile_number_q;
	logic signed [COORD_W-1:0] origin_x_q;
	logic signed [COORD_W-1:0] origin_y_q;
	logic [COLOUR_W-1:0]       key_colour_q;
	logic [BASE_W-1:0]         tile_base_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sheet_width_q  <= DIM_W'(16);
			sheet_height_q <= DIM_W'(16);
			tile_width_q   <= DIM_W'(16);
			tile_number_q  <= '0;
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			key_colour_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SHEET_WIDTH:  sheet_width_q  <= cfg_data[DIM_W-1:0];
				CFG_SHEET_HEIGHT: sheet_height_q <= cfg_data[DIM_W-1:0];
				CFG_TILE_WIDTH:   tile_width_q   <= cfg_data[DIM_W-1:0];
				CFG_TILE_NUMBER:  tile_number_q  <= cfg_data[TNUM_W-1:0];
				CFG_ORIGIN_X:     origin_x_q     <= $signed(cfg_data[COORD_W-1:0]);
				CFG_ORIGIN_Y:     origin_y_q     <= $signed(cfg_data[COORD_W-1:0]);
				CFG_KEY_COLOUR:   key_colour_q   <= cfg_data[COLOUR_W-1:0];
				default: ;
			endcase
		end
	end

	// first sheet column of the selected tile, registered from tile number times tile width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_base_q <= '0;
		end else begin
			tile_base_q <= BASE_W'(tile_number_q) * BASE_W'(tile_width_q);
		end
	end

	always_comb begin
		cfg.sheet_width  = sheet_width_q;
		cfg.sheet_height = sheet_height_q;
		cfg.tile_width   = tile_width_q;
		cfg.origin_x     = origin_x_q;
		cfg.origin_y     = origin_y_q;
		cfg.key_colour   = key_colour_q;
		cfg.tile_base    = tile_base_q;
	end

endmodule

`default_nettype wire

// ===== rtl/cckb_sheet_pos.sv =====
// sheet column and row tracking for the tile blitter
// depends on cckb_pkg and the assertion macro header
`default_nettype none

`include "clipped_colour_key_tile_blitter_core_macros.svh"

module cckb_sheet_pos
	import cckb_pkg::*;
#(
	parameter int MAX_SHEET_SIZE = 1024,
	localparam int CNT_W = $clog2(MAX_SHEET_SIZE),
	localparam int LIM_W = CNT_W + 1,
	localparam int EXT_W = (LIM_W > DIM_W) ? LIM_W : DIM_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  cfg_t                  cfg,
	input  wire logic             accept,
	input  wire logic             first_word,
	output logic      [CNT_W-1:0] cur_col,
	output logic      [CNT_W-1:0] cur_row,
	output logic                  live
);

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic             past_end_q;
	logic             cur_past_end;
	logic [EXT_W-1:0] sw_ext;
	logic [EXT_W-1:0] sh_ext;
	logic [EXT_W-1:0] w_eff;
	logic [EXT_W-1:0] h_lim;
	logic             wrap;
	logic             last_row;

	// position of this word: a first word restarts the sheet
	always_comb begin
		cur_col      = first_word ? '0 : col_q;
		cur_row      = first_word ? '0 : row_q;
		cur_past_end = first_word ? 1'b0 : past_end_q;
	end

	// clamped sheet size
	always_comb begin
		sw_ext = EXT_W'(cfg.sheet_width);
		sh_ext = EXT_W'(cfg.sheet_height);
		if (sw_ext == '0) begin
			w_eff = EXT_W'(1);
		end else if (sw_ext > EXT_W'(MAX_SHEET_SIZE)) begin
			w_eff = EXT_W'(MAX_SHEET_SIZE);
		end else begin
			w_eff = sw_ext;
		end
		h_lim    = (sh_ext > EXT_W'(MAX_SHEET_SIZE)) ? EXT_W'(MAX_SHEET_SIZE) : sh_ext;
		wrap     = (EXT_W'(cur_col) + EXT_W'(1)) >= w_eff;
		last_row = (EXT_W'(cur_row) + EXT_W'(1)) >= h_lim;
		live     = !cur_past_end && (EXT_W'(cur_row) < sh_ext);
	end

	// counter advance on every accepted word, held once past the end of the sheet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			past_end_q <= 1'b0;
		end else if (accept) begin
			col_q      <= cur_col;
			row_q      <= cur_row;
			past_end_q <= cur_past_end;
			if (!cur_past_end) begin
				if (wrap) begin
					col_q <= '0;
					if (last_row) begin
						past_end_q <= 1'b1;
					end else begin
						row_q <= cur_row + CNT_W'(1);
					end
				end else begin
					col_q <= cur_col + CNT_W'(1);
				end
			end
		end
	end

	`CCKB_ASSERT_NOW(a_end_parks_column, past_end_q, col_q == '0, "column not parked at end of sheet")
	`CCKB_ASSERT_NEXT(a_first_word_restarts, accept && first_word && !wrap, row_q == '0 && !past_end_q, "first word did not restart the sheet position")

endmodule

`default_nettype wire

// ===== rtl/cckb_pixel_stage.sv =====
// input register, tile/clip/key test and result register of the tile blitter
// depends on cckb_pkg and the assertion macro header
`default_nettype none

`include "clipped_colour_key_tile_blitter_core_macros.svh"

module cckb_pixel_stage
	import cckb_pkg::*;
#(
	parameter int MAX_SHEET_SIZE = 1024,
	localparam int CNT_W = $clog2(MAX_SHEET_SIZE)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  cfg_t                     cfg,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [COLOUR_W-1:0] in_word,
	input  wire logic [CNT_W-1:0]    in_col,
	input  wire logic [CNT_W-1:0]    in_row,
	input  wire logic                in_live,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [SX_OUT_W-1:0]      out_x,
	output logic [SY_OUT_W-1:0]      out_y,
	output logic [COLOUR_W-1:0]      out_colour
);

	logic                     valid_s1;
	logic [COLOUR_W-1:0]      word_s1;
	logic [CNT_W-1:0]         col_s1;
	logic [CNT_W-1:0]         row_s1;
	logic                     live_s1;
	logic                     out_valid_q;
	logic [SX_OUT_W-1:0]      sx_q;
	logic [SY_OUT_W-1:0]      sy_q;
	logic [COLOUR_W-1:0]      colour_q;
	logic                     out_free;
	logic                     load_s1;
	logic [DIFF_W-1:0]        col_diff;
	logic                     in_tile;
	logic signed [SUM_W-1:0]  sx;
	logic signed [SUM_W-1:0]  sy;
	logic                     on_screen;
	logic                     hit;

	// handshake: the result register frees the input register
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || out_free;
	assign load_s1  = in_valid && in_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			word_s1 <= in_word;
			col_s1  <= in_col;
			row_s1  <= in_row;
			live_s1 <= in_live;
		end
	end

	// tile window, screen placement, clipping and colour key
	always_comb begin
		col_diff  = DIFF_W'(col_s1) - DIFF_W'(cfg.tile_base);
		in_tile   = (DIFF_W'(col_s1) >= DIFF_W'(cfg.tile_base))
			&& (col_diff < DIFF_W'(cfg.tile_width));
		sx        = SUM_W'(cfg.origin_x) + $signed(SUM_W'(col_diff[DIM_W-1:0]));
		sy        = SUM_W'(cfg.origin_y) + $signed(SUM_W'(row_s1));
		on_screen = !sx[SUM_W-1] && (sx < $signed(SUM_W'(SCREEN_WIDTH)))
			&& !sy[SUM_W-1] && (sy < $signed(SUM_W'(SCREEN_HEIGHT)));
		hit       = live_s1 && in_tile && on_screen && (word_s1 != cfg.key_colour);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && hit) begin
			sx_q     <= sx[SX_OUT_W-1:0];
			sy_q     <= sy[SY_OUT_W-1:0];
			colour_q <= word_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_x      = sx_q;
	assign out_y      = sy_q;
	assign out_colour = colour_q;

	`CCKB_ASSERT_NOW(a_held_item_blocks_input, valid_s1 && !out_free, !in_ready, "input taken while the held item is stalled")
	`CCKB_ASSERT_NOW(a_result_on_screen, out_valid_q, (32'(sx_q) < SCREEN_WIDTH) && (32'(sy_q) < SCREEN_HEIGHT), "pixel write outside the screen")
	`CCKB_ASSERT_NOW(a_result_not_key, out_valid_q, colour_q != cfg.key_colour, "transparent colour written")
	`CCKB_ASSERT_NEXT(a_no_result_without_item, !valid_s1 && out_free, !out_valid_q, "pixel write without a request")

endmodule

`default_nettype wire

// ===== rtl/clipped_colour_key_tile_blitter_core.sv =====
// colour-keyed tile blitter with screen clipping, top level
// depends on cckb_pkg, cckb_cfg_regs, cckb_sheet_pos and cckb_pixel_stage
//
// channel  | direction | contents
// s_axis   | in        | tdata[15:0] pixel_word, tuser[0] first_word
// m_axis   | out       | tdata[8:0] screen_x, [16:9] screen_y, [32:17] colour, [39:33] zero
// cfg      | in        | cfg_we, cfg_index (register 0..6), cfg_data
//
// one request is taken per cycle while s_tready is high; a taken request waits in the input
// register, and when the result register is free its pixel write, if it passes the tests,
// moves there and is offered on m_axis. the input register and the result register each hold
// one item: while a result waits, one more request is taken, then s_tready stays low.
// reset clears the sheet position and loads the register reset values.
// a tile number or tile width write reaches the tile start product in the cycle after the registers change.
`default_nettype none

module clipped_colour_key_tile_blitter_core
	import cckb_pkg::*;
#(
	parameter int MAX_SHEET_SIZE = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// stream in
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,    // [15:0] pixel_word
	input  wire logic [0:0]            s_tuser,    // [0] first_word
	// stream out
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,    // [8:0] screen_x, [16:9] screen_y,
	                                               // [32:17] colour, [39:33] zero
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_SHEET_SIZE);

	cfg_t                cfg;
	logic                accept;
	logic [CNT_W-1:0]    cur_col;
	logic [CNT_W-1:0]    cur_row;
	logic                live;
	logic [SX_OUT_W-1:0] screen_x;
	logic [SY_OUT_W-1:0] screen_y;
	logic [COLOUR_W-1:0] colour;

	assign accept = s_tvalid && s_tready;

	// configuration registers
	cckb_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sheet position counters
	cckb_sheet_pos #(
		.MAX_SHEET_SIZE (MAX_SHEET_SIZE)
	) u_sheet_pos (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.accept     (accept),
		.first_word (s_tuser[0]),
		.cur_col    (cur_col),
		.cur_row    (cur_row),
		.live       (live)
	);

	// pixel test and result register
	cckb_pixel_stage #(
		.MAX_SHEET_SIZE (MAX_SHEET_SIZE)
	) u_pixel_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_word    (s_tdata[COLOUR_W-1:0]),
		.in_col     (cur_col),
		.in_row     (cur_row),
		.in_live    (live),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_x      (screen_x),
		.out_y      (screen_y),
		.out_colour (colour)
	);

	// output packing
	assign m_tdata = {OUT_PAD_W'(0), colour, screen_y, screen_x};

endmodule

`default_nettype wire
